[design/lru_replacement_tracker_defines.svh]
`ifndef LRU_REPLACEMENT_TRACKER_DEFINES_SVH
`define LRU_REPLACEMENT_TRACKER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LRT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/lrt_pkg.sv]
package lrt_pkg;

   localparam int FRAMES  = 64;
   localparam int FRAME_W = 6;
   localparam int COUNT_W = 7;

   typedef logic [1:0]         op_type;
   typedef logic [FRAME_W-1:0] frame_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_VICTIM = 2'd1;
   localparam op_type OP_ERASE  = 2'd2;

endpackage

[design/lrt_channels.sv]
interface lrt_req_if;
   logic               valid;
   logic               ready;
   lrt_pkg::op_type    operation;
   lrt_pkg::frame_type frame_index;

   modport source (output valid, output operation, output frame_index, input ready);
   modport sink   (input valid, input operation, input frame_index, output ready);
endinterface

interface lrt_rsp_if;
   logic               valid;
   logic               ready;
   logic               success;
   lrt_pkg::frame_type victim_frame;
   lrt_pkg::count_type occupancy;

   modport source (output valid, output success, output victim_frame, output occupancy,
                   input ready);
   modport sink   (input valid, input success, input victim_frame, input occupancy,
                   output ready);
endinterface

[design/lru_replacement_tracker.sv]
// Channel   Dir  Payload                                  Accepted when
// req_chan  in   operation, frame_index                   valid && ready
// rsp_chan  out  success, victim_frame, occupancy         valid && ready
//
// Victim and erase pass through the link memory read and an unlink step;
// insert then also appends at the head in a step of its own.
// That separate append step is set by the single write port of each link memory.
// Reset is synchronous and clears presence bits, list ends and count.
// A new request is taken as soon as the previous one finishes, even while its
// response still waits; the last step stalls only if the response slot is full.
`include "lru_replacement_tracker_defines.svh"

module lru_replacement_tracker (
   input logic        clock,
   input logic        reset,
   lrt_req_if.sink    req_chan,
   lrt_rsp_if.source  rsp_chan
);

   typedef enum logic [1:0] {S_IDLE, S_FIX, S_APPEND} state_type;

   state_type                state_ff, state_in;
   lrt_pkg::op_type          op_ff, op_in;
   lrt_pkg::frame_type       frame_ff, frame_in;
   logic [lrt_pkg::FRAMES-1:0] present_ff, present_in;
   lrt_pkg::frame_type       oldest_ff, oldest_in;
   lrt_pkg::frame_type       newest_ff, newest_in;
   lrt_pkg::count_type       count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_success_ff, rsp_success_in;
   lrt_pkg::frame_type       rsp_victim_ff, rsp_victim_in;
   lrt_pkg::count_type       rsp_occ_ff, rsp_occ_in;

   logic                     req_accept;
   logic                     slot_free;
   lrt_pkg::frame_type       rd_addr;
   logic                     newer_we, older_we;
   lrt_pkg::frame_type       newer_waddr, newer_wdata, older_waddr, older_wdata;
   lrt_pkg::frame_type       newer_rdata, older_rdata;
   logic                     in_range;
   logic                     do_unlink;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign rd_addr        = (req_chan.operation == lrt_pkg::OP_VICTIM) ? oldest_ff
                                                                      : req_chan.frame_index;

   lrt_link_ram #(.DEPTH(lrt_pkg::FRAMES), .WIDTH(lrt_pkg::FRAME_W)) u_newer_ram (
      .clock   (clock),
      .wr_en   (newer_we),
      .wr_addr (newer_waddr),
      .wr_data (newer_wdata),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (newer_rdata)
   );

   lrt_link_ram #(.DEPTH(lrt_pkg::FRAMES), .WIDTH(lrt_pkg::FRAME_W)) u_older_ram (
      .clock   (clock),
      .wr_en   (older_we),
      .wr_addr (older_waddr),
      .wr_data (older_wdata),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (older_rdata)
   );

   assign in_range  = ({1'b0, frame_ff} < lrt_pkg::COUNT_W'(lrt_pkg::FRAMES));
   assign do_unlink = in_range && (((op_ff == lrt_pkg::OP_INSERT ||
                                     op_ff == lrt_pkg::OP_ERASE) && present_ff[frame_ff]) ||
                                   (op_ff == lrt_pkg::OP_VICTIM && count_ff != '0));

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      frame_in       = frame_ff;
      present_in     = present_ff;
      oldest_in      = oldest_ff;
      newest_in      = newest_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_success_in = rsp_success_ff;
      rsp_victim_in  = rsp_victim_ff;
      rsp_occ_in     = rsp_occ_ff;
      newer_we       = 1'b0;
      newer_waddr    = older_rdata;
      newer_wdata    = newer_rdata;
      older_we       = 1'b0;
      older_waddr    = newer_rdata;
      older_wdata    = older_rdata;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in    = req_chan.operation;
               frame_in = rd_addr;
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            if ((op_ff == lrt_pkg::OP_INSERT && in_range) || slot_free) begin
               if (do_unlink) begin
                  // splice neighbors around the target, or move the list ends
                  if (frame_ff == oldest_ff) begin
                     oldest_in = newer_rdata;
                  end else begin
                     newer_we = 1'b1;
                  end
                  if (frame_ff == newest_ff) begin
                     newest_in = older_rdata;
                  end else begin
                     older_we = 1'b1;
                  end
                  present_in[frame_ff] = 1'b0;
                  count_in = count_ff - lrt_pkg::COUNT_W'(1);
               end
               if (op_ff == lrt_pkg::OP_INSERT && in_range) begin
                  state_in = S_APPEND;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_success_in = do_unlink;
                  rsp_victim_in  = (op_ff == lrt_pkg::OP_VICTIM && do_unlink) ? frame_ff : '0;
                  rsp_occ_in     = do_unlink ? count_ff - lrt_pkg::COUNT_W'(1) : count_ff;
                  state_in       = S_IDLE;
               end
            end
         end
         S_APPEND: begin
            if (slot_free) begin
               newer_we    = (count_ff != '0);
               newer_waddr = newest_ff;
               newer_wdata = frame_ff;
               older_we    = 1'b1;
               older_waddr = frame_ff;
               older_wdata = (count_ff == '0) ? frame_ff : newest_ff;
               if (count_ff == '0) begin
                  oldest_in = frame_ff;
               end
               newest_in            = frame_ff;
               present_in[frame_ff] = 1'b1;
               count_in             = count_ff + lrt_pkg::COUNT_W'(1);
               rsp_valid_in         = 1'b1;
               rsp_success_in       = 1'b1;
               rsp_victim_in        = '0;
               rsp_occ_in           = count_ff + lrt_pkg::COUNT_W'(1);
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         present_ff   <= '0;
         oldest_ff    <= '0;
         newest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         oldest_ff    <= oldest_in;
         newest_ff    <= newest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      frame_ff       <= frame_in;
      rsp_success_ff <= rsp_success_in;
      rsp_victim_ff  <= rsp_victim_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.success      = rsp_success_ff;
   assign rsp_chan.victim_frame = rsp_victim_ff;
   assign rsp_chan.occupancy    = rsp_occ_ff;

   `LRT_ASSERT_SAME(a_count_matches_present, clock, reset, 1'b1,
      lrt_pkg::COUNT_W'($countones(present_ff)) == count_ff,
      "tracked count disagrees with presence bits")
   `LRT_ASSERT_SAME(a_no_write_when_idle, clock, reset, newer_we || older_we,
      state_ff != S_IDLE, "link memory written while idle")
   `LRT_ASSERT_NEXT(a_accept_reads_links, clock, reset, req_accept,
      state_ff == S_FIX, "accepted request did not move to unlink step")
   `LRT_ASSERT_SAME(a_victim_is_present, clock, reset,
      state_ff == S_FIX && op_ff == lrt_pkg::OP_VICTIM && count_ff != '0,
      present_ff[frame_ff], "oldest frame is not marked present")

endmodule

[design/lrt_link_ram.sv]
module lrt_link_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
